>>> rtl/skt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    typedef enum logic [2:0] {
        FUNC_INSERT = 3'd0,
        FUNC_DELETE = 3'd1,
        FUNC_FIRST  = 3'd2,
        FUNC_FIND   = 3'd3,
        FUNC_START  = 3'd4,
        FUNC_SEEK   = 3'd5,
        FUNC_NEXT   = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_NONE = 2'd1,
        STATUS_DUP  = 2'd2,
        STATUS_FULL = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMPARE,
        S_TREE,
        S_APPLY,
        S_DONE
    } state_t;

    // Which cell, if any, drives its entry into the read tree.
    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_MATCH,
        SEL_GTE,
        SEL_FIRST,
        SEL_MARK
    } sel_t;

    typedef struct packed {
        logic compare;
        sel_t sel;
        logic ins;
        logic del;
        logic seek;
        logic next;
        logic start;
        logic start_rev;
        logic iter_rev;
    } skt_ctrl_t;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic [63:0] key;
        logic        lt;
        logic        mark;
        logic        valid;
    } skt_link_t;

endpackage

`default_nettype wire

>>> rtl/skt_read_tree.sv
`timescale 1ns / 1ps
`default_nettype none

module skt_read_tree #(
    parameter int LEAVES = 2,
    parameter int WIDTH  = 1
) (
    input  wire logic             clk,
    input  wire logic [WIDTH-1:0] leaf [LEAVES],
    output logic      [WIDTH-1:0] root
);

    localparam int LEVELS = $clog2(LEAVES);
    localparam int PADDED = 1 << LEVELS;
    localparam int NODES  = 2 * PADDED - 1;

    logic [WIDTH-1:0] leaf_pad [PADDED];
    logic [WIDTH-1:0] node_reg [NODES];

    for (genvar j = 0; j < PADDED; j++) begin : g_pad
        if (j < LEAVES) begin : g_real
            assign leaf_pad[j] = leaf[j];
        end
        else begin : g_zero
            assign leaf_pad[j] = '0;
        end
    end

    // Heap layout: node i has children 2i+1 and 2i+2, leaves at the end.
    // At most one leaf is nonzero, so an OR at each node forwards it.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < PADDED; j++)
        begin
            node_reg[PADDED - 1 + j] <= leaf_pad[j];
        end
        for (int i = 0; i < PADDED - 1; i++)
        begin
            node_reg[i] <= node_reg[2 * i + 1] | node_reg[2 * i + 2];
        end
    end

    assign root = node_reg[0];

endmodule

`default_nettype wire

>>> rtl/skt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module skt_cell import skt_pkg::*; #(
    parameter int IDX   = 0,
    parameter int HB    = 32,
    parameter int CNT_W = 9
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire skt_ctrl_t         ctrl,
    input  wire logic [CNT_W-1:0]  count,
    input  wire logic [63:0]       req_key,
    input  wire logic [HB-1:0]     req_handle,
    input  wire skt_link_t         left,
    input  wire logic [HB-1:0]     left_handle,
    input  wire skt_link_t         right,
    input  wire logic [HB-1:0]     right_handle,
    output skt_link_t              self_link,
    output logic      [HB-1:0]     self_handle,
    output logic                   leaf_hit,
    output logic      [63:0]       leaf_key,
    output logic      [HB-1:0]     leaf_handle
);

    logic [63:0]   key_reg;
    logic [63:0]   key_next;
    logic [HB-1:0] handle_reg;
    logic [HB-1:0] handle_next;
    logic          lt_reg;
    logic          eq_reg;
    logic          mark_reg;
    logic          mark_next;
    logic          valid;
    logic          at_p;
    logic          right_at_p;
    logic          sel;

    assign valid      = CNT_W'(IDX) < count;
    // This cell is the insertion point when it is the first not below the key.
    assign at_p       = !lt_reg && left.lt;
    assign right_at_p = lt_reg && !right.lt;

    always_comb
    begin
        case (ctrl.sel)
            SEL_MATCH: sel = at_p && valid && eq_reg;
            SEL_GTE:   sel = at_p && valid;
            SEL_FIRST: sel = (IDX == 0) && valid;
            SEL_MARK:  sel = mark_reg;
            default:   sel = 1'b0;
        endcase
    end

    assign leaf_hit    = sel;
    assign leaf_key    = sel ? key_reg : '0;
    assign leaf_handle = sel ? handle_reg : '0;

    always_comb
    begin
        key_next    = key_reg;
        handle_next = handle_reg;
        mark_next   = mark_reg;
        if (ctrl.ins && !lt_reg)
        begin
            if (at_p)
            begin
                key_next    = req_key;
                handle_next = req_handle;
                mark_next   = 1'b0;
            end
            else
            begin
                key_next    = left.key;
                handle_next = left_handle;
                mark_next   = left.mark;
            end
        end
        else if (ctrl.del)
        begin
            if (!lt_reg)
            begin
                key_next    = right.key;
                handle_next = right_handle;
                mark_next   = right.mark
                              | (at_p && mark_reg && !ctrl.iter_rev && right.valid);
            end
            else
            begin
                mark_next = mark_reg | (right_at_p && right.mark && ctrl.iter_rev);
            end
        end
        else if (ctrl.seek)
        begin
            mark_next = at_p && valid;
        end
        else if (ctrl.next)
        begin
            mark_next = ctrl.iter_rev ? right.mark : (left.mark && valid);
        end
        else if (ctrl.start)
        begin
            mark_next = ctrl.start_rev ? (valid && !right.valid)
                                       : ((IDX == 0) && valid);
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
        if (ctrl.compare)
        begin
            lt_reg <= valid && ($signed(key_reg) < $signed(req_key));
            eq_reg <= key_reg == req_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 1'b0;
        end
        else
        begin
            mark_reg <= mark_next;
        end
    end

    assign self_link.key   = key_reg;
    assign self_link.lt    = lt_reg;
    assign self_link.mark  = mark_reg;
    assign self_link.valid = valid;
    assign self_handle     = handle_reg;

endmodule

`default_nettype wire

>>> rtl/sorted_key_table.sv
// Ordered table of signed 64-bit keys with a value handle per entry.
// Input channel (in_valid / in_stall) carries one request word: func, key,
// handle_in, unique_only and reverse_dir. Output channel (out_valid /
// out_stall) returns exactly one result word per request: status, key_out,
// handle_out and entry_count (the entry count after the request).
// Entries live in a row of CAPACITY cells in ascending order. Every cell
// compares its key with the request key at once; each cell then knows from
// its own flag and its left neighbor's flag whether it lies below, at or
// above the insertion point, and shifts left or right by one in the apply
// state. The iterator is a marker bit that travels with its entry.
// Reads go through a registered OR tree of log2(CAPACITY) levels; a request
// passes the compare, tree, apply and done states, and the tree depth sets
// how long the tree state lasts. One request is in flight at a time; the
// next one is accepted as soon as the previous result is in the output
// register, even if that word is still stalled. A stalled result holds its
// word until taken, and the block then waits with the following result until
// the register frees.
// Reset empties the table and ends the iterator; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table import skt_pkg::*; #(
    parameter int CAPACITY    = 256,
    parameter int HANDLE_BITS = 32,
    localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [2:0]        func,
    input  wire logic signed [63:0] key,
    input  wire logic [31:0]       handle_in,
    input  wire logic              unique_only,
    input  wire logic              reverse_dir,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             status,
    output logic signed [63:0]     key_out,
    output logic [31:0]            handle_out,
    output logic [CNT_W-1:0]       entry_count
);

    // Handles arrive on a 32-bit port, so no more than 32 bits are kept.
    localparam int HB       = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
    localparam int LEVELS   = $clog2(CAPACITY);
    localparam int TREE_LAT = LEVELS + 1;
    localparam int WAIT_W   = $clog2(TREE_LAT + 1);
    localparam int LEAF_W   = 1 + 64 + HB;

    state_t            state_reg;
    state_t            state_next;
    func_t             func_reg;
    logic [63:0]       key_reg;
    logic [HB-1:0]     hin_reg;
    logic              uniq_reg;
    logic              rev_reg;
    logic              iter_rev_reg;
    logic              iter_rev_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [WAIT_W-1:0] wait_reg;
    logic [WAIT_W-1:0] wait_next;

    status_t           res_status_reg;
    status_t           res_status_next;
    logic [63:0]       res_key_reg;
    logic [63:0]       res_key_next;
    logic [31:0]       res_handle_reg;
    logic [31:0]       res_handle_next;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [63:0]       out_key_reg;
    logic [31:0]       out_handle_reg;
    logic [CNT_W-1:0]  out_count_reg;

    logic              accept;
    logic              out_load;
    logic              full;
    logic              hit;
    logic              ins_ok;
    logic [63:0]       root_key;
    logic [HB-1:0]     root_handle;
    logic [LEAF_W-1:0] root;
    skt_ctrl_t         ctrl;

    skt_link_t         link     [CAPACITY];
    logic [HB-1:0]     link_h   [CAPACITY];
    logic [LEAF_W-1:0] leaf     [CAPACITY];

    localparam skt_link_t EDGE_LEFT  = '{key: '0, lt: 1'b1, mark: 1'b0, valid: 1'b1};
    localparam skt_link_t EDGE_RIGHT = '{key: '0, lt: 1'b0, mark: 1'b0, valid: 1'b0};

    assign in_stall = state_reg != S_IDLE;
    assign accept   = in_valid && !in_stall;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // The cell row. Each cell sees its two neighbors; the ends see fixed links.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        skt_link_t     left_l;
        skt_link_t     right_l;
        logic [HB-1:0] left_hh;
        logic [HB-1:0] right_hh;
        logic          c_hit;
        logic [63:0]   c_key;
        logic [HB-1:0] c_handle;

        if (g == 0) begin : g_l_edge
            assign left_l  = EDGE_LEFT;
            assign left_hh = '0;
        end
        else begin : g_l_cell
            assign left_l  = link[g - 1];
            assign left_hh = link_h[g - 1];
        end

        if (g == CAPACITY - 1) begin : g_r_edge
            assign right_l  = EDGE_RIGHT;
            assign right_hh = '0;
        end
        else begin : g_r_cell
            assign right_l  = link[g + 1];
            assign right_hh = link_h[g + 1];
        end

        skt_cell #(
            .IDX   (g),
            .HB    (HB),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .count        (count_reg),
            .req_key      (key_reg),
            .req_handle   (hin_reg),
            .left         (left_l),
            .left_handle  (left_hh),
            .right        (right_l),
            .right_handle (right_hh),
            .self_link    (link[g]),
            .self_handle  (link_h[g]),
            .leaf_hit     (c_hit),
            .leaf_key     (c_key),
            .leaf_handle  (c_handle)
        );

        assign leaf[g] = {c_hit, c_key, c_handle};
    end

    skt_read_tree #(
        .LEAVES (CAPACITY),
        .WIDTH  (LEAF_W)
    ) u_tree (
        .clk  (clk),
        .leaf (leaf),
        .root (root)
    );

    assign hit         = root[LEAF_W-1];
    assign root_key    = root[HB +: 64];
    assign root_handle = root[HB-1:0];
    assign full        = count_reg == CNT_W'(CAPACITY);
    // A duplicate check comes before the full check.
    assign ins_ok      = !(uniq_reg && hit) && !full;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                state_next = S_TREE;
                wait_next  = '0;
            end
            S_TREE:
            begin
                if (wait_reg == WAIT_W'(TREE_LAT - 1))
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    wait_next = wait_reg + 1'b1;
                end
            end
            S_APPLY:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Cell controls. The read select stays steady from compare through apply.
    always_comb
    begin
        ctrl           = '0;
        ctrl.compare   = state_reg == S_COMPARE;
        ctrl.start_rev = rev_reg;
        ctrl.iter_rev  = iter_rev_reg;
        case (func_reg)
            FUNC_INSERT: ctrl.sel = SEL_MATCH;
            FUNC_DELETE: ctrl.sel = SEL_MATCH;
            FUNC_FIRST:  ctrl.sel = SEL_FIRST;
            FUNC_FIND:   ctrl.sel = SEL_GTE;
            FUNC_SEEK:   ctrl.sel = SEL_GTE;
            FUNC_NEXT:   ctrl.sel = SEL_MARK;
            default:     ctrl.sel = SEL_NONE;
        endcase
        if (state_reg == S_APPLY)
        begin
            ctrl.ins   = (func_reg == FUNC_INSERT) && ins_ok;
            ctrl.del   = (func_reg == FUNC_DELETE) && hit;
            ctrl.seek  = func_reg == FUNC_SEEK;
            ctrl.next  = func_reg == FUNC_NEXT;
            ctrl.start = func_reg == FUNC_START;
        end
    end

    // Result word and the count, settled in the apply cycle.
    always_comb
    begin
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_handle_next = res_handle_reg;
        count_next      = count_reg;
        iter_rev_next   = iter_rev_reg;
        if (state_reg == S_APPLY)
        begin
            res_key_next    = root_key;
            res_handle_next = 32'(root_handle);
            res_status_next = hit ? STATUS_OK : STATUS_NONE;
            case (func_reg)
                FUNC_INSERT:
                begin
                    res_key_next    = key_reg;
                    res_handle_next = 32'(hin_reg);
                    if (uniq_reg && hit)
                    begin
                        res_status_next = STATUS_DUP;
                    end
                    else if (full)
                    begin
                        res_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        res_status_next = STATUS_OK;
                        count_next      = count_reg + 1'b1;
                    end
                end
                FUNC_DELETE:
                begin
                    if (hit)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                FUNC_START:
                begin
                    res_status_next = STATUS_OK;
                    res_key_next    = '0;
                    res_handle_next = '0;
                    iter_rev_next   = rev_reg;
                end
                FUNC_FIRST, FUNC_FIND, FUNC_SEEK, FUNC_NEXT:
                begin
                end
                default:
                begin
                    res_status_next = STATUS_NONE;
                    res_key_next    = '0;
                    res_handle_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            iter_rev_reg  <= 1'b0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            iter_rev_reg <= iter_rev_next;
            wait_reg     <= wait_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(func);
            key_reg  <= key;
            hin_reg  <= handle_in[HB-1:0];
            uniq_reg <= unique_only;
            rev_reg  <= reverse_dir;
        end
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_handle_reg <= res_handle_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_key_reg    <= res_key_reg;
            out_handle_reg <= res_handle_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign key_out     = out_key_reg;
    assign handle_out  = out_handle_reg;
    assign entry_count = out_count_reg;

endmodule

`default_nettype wire

>>> verif/sorted_key_table_tb.sv
`timescale 1ns / 1ps

module sorted_key_table_tb;
    import skt_pkg::*;

    localparam int CAPACITY     = 256;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASE_LEN    = RANDOM_ITEMS / 4;
    localparam int DIRECTED     = 25;
    // The drain wait lasts well past a request's trip through the block.
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300000;
    // A quiet window with neither side idling, so back-to-back traffic is covered too.
    localparam int CALM_FROM    = 4000;
    localparam int CALM_TO      = 7000;

    // The selector value that the block leaves unused.
    localparam logic [2:0] FUNC_UNUSED = 3'd7;

    localparam logic signed [63:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] KEY_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        status_t            status;
        logic signed [63:0] key;
        logic [31:0]        handle;
        logic [8:0]         count;
    } result_t;

    // One row of the directed part. Where known is set, want holds the result
    // word typed in by hand; otherwise the table model supplies it.
    typedef struct packed {
        logic [2:0]         fn;
        logic signed [63:0] key;
        logic [31:0]        handle;
        logic               uniq;
        logic               rev;
        logic               known;
        result_t            want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] func;
    logic signed [63:0] key;
    logic [31:0] handle_in;
    logic unique_only;
    logic reverse_dir;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic signed [63:0] key_out;
    logic [31:0] handle_out;
    logic [8:0] entry_count;

    sorted_key_table u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .key         (key),
        .handle_in   (handle_in),
        .unique_only (unique_only),
        .reverse_dir (reverse_dir),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .key_out     (key_out),
        .handle_out  (handle_out),
        .entry_count (entry_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    int cycle_no = 0;
    int errors = 0;

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
    end

    // Our own copy of the ordered table: ascending keys, equal keys in the
    // order the block keeps them, plus the single iterator.
    logic signed [63:0] tbl_key [CAPACITY];
    logic [31:0]        tbl_handle [CAPACITY];
    int                 tbl_count = 0;
    int                 iter_at = 0;
    bit                 iter_back = 1'b0;
    bit                 iter_live = 1'b0;

    // Result words owed by the block, oldest first.
    result_t pending_results [$];

    function automatic bit calm();
        return cycle_no >= CALM_FROM && cycle_no < CALM_TO;
    endfunction

    // Index of the first entry whose key is at or above k, or the count if none.
    function automatic int first_at_or_above(input logic signed [63:0] k);
        int i;
        i = 0;
        while (i < tbl_count && tbl_key[i] < k)
            i++;
        return i;
    endfunction

    // Applies one request word to the table copy and returns the result word
    // the block must give for it.
    function automatic result_t apply_to_table(input logic [2:0] fn,
                                               input logic signed [63:0] k,
                                               input logic [31:0] h,
                                               input logic uq,
                                               input logic rv);
        result_t r;
        int p;
        int i;
        r.status = STATUS_NONE;
        r.key    = '0;
        r.handle = '0;
        case (fn)
            FUNC_INSERT:
            begin
                p = first_at_or_above(k);
                // The key and handle offered are echoed whatever happens.
                r.key    = k;
                r.handle = h;
                if (uq && p < tbl_count && tbl_key[p] == k)
                    r.status = STATUS_DUP;
                else if (tbl_count >= CAPACITY)
                    r.status = STATUS_FULL;
                else
                begin
                    for (i = tbl_count; i > p; i--)
                    begin
                        tbl_key[i]    = tbl_key[i - 1];
                        tbl_handle[i] = tbl_handle[i - 1];
                    end
                    tbl_key[p]    = k;
                    tbl_handle[p] = h;
                    tbl_count++;
                    // The iterator keeps its entry when something lands in front of it.
                    if (iter_live && iter_at >= p)
                        iter_at++;
                    r.status = STATUS_OK;
                end
            end
            FUNC_DELETE:
            begin
                p = first_at_or_above(k);
                if (p < tbl_count && tbl_key[p] == k)
                begin
                    r.status = STATUS_OK;
                    r.key    = tbl_key[p];
                    r.handle = tbl_handle[p];
                    for (i = p; i + 1 < tbl_count; i++)
                    begin
                        tbl_key[i]    = tbl_key[i + 1];
                        tbl_handle[i] = tbl_handle[i + 1];
                    end
                    tbl_count--;
                    if (iter_live)
                    begin
                        if (iter_at > p)
                            iter_at--;
                        else if (iter_at == p)
                        begin
                            // The iterator's own entry went away: step to the
                            // neighbor in the direction of travel.
                            if (iter_back)
                            begin
                                if (p == 0)
                                    iter_live = 1'b0;
                                else
                                    iter_at = p - 1;
                            end
                            else if (p >= tbl_count)
                                iter_live = 1'b0;
                        end
                    end
                end
            end
            FUNC_FIRST:
            begin
                if (tbl_count > 0)
                begin
                    r.status = STATUS_OK;
                    r.key    = tbl_key[0];
                    r.handle = tbl_handle[0];
                end
            end
            FUNC_FIND:
            begin
                p = first_at_or_above(k);
                if (p < tbl_count)
                begin
                    r.status = STATUS_OK;
                    r.key    = tbl_key[p];
                    r.handle = tbl_handle[p];
                end
            end
            FUNC_START:
            begin
                iter_back = rv;
                iter_live = tbl_count > 0;
                iter_at   = (rv && tbl_count > 0) ? tbl_count - 1 : 0;
                r.status  = STATUS_OK;
            end
            FUNC_SEEK:
            begin
                p = first_at_or_above(k);
                if (p < tbl_count)
                begin
                    iter_at   = p;
                    iter_live = 1'b1;
                    r.status  = STATUS_OK;
                    r.key     = tbl_key[p];
                    r.handle  = tbl_handle[p];
                end
                else
                    iter_live = 1'b0;
            end
            FUNC_NEXT:
            begin
                if (!iter_live || iter_at >= tbl_count)
                    iter_live = 1'b0;
                else
                begin
                    p = iter_at;
                    r.status = STATUS_OK;
                    r.key    = tbl_key[p];
                    r.handle = tbl_handle[p];
                    if (iter_back)
                    begin
                        if (p == 0)
                            iter_live = 1'b0;
                        else
                            iter_at = p - 1;
                    end
                    else
                    begin
                        iter_at = p + 1;
                        if (iter_at >= tbl_count)
                            iter_live = 1'b0;
                    end
                end
            end
            default:
            begin
                // The unused selector changes nothing.
            end
        endcase
        r.count = 9'(tbl_count);
        return r;
    endfunction

    // Directed part: empty-table cases first, then the key extremes, a
    // refused duplicate, an equal key placed in front, and the iterator
    // following its entry through a delete in each direction and through an
    // insert in front of it. Rows with known = 0 are checked by the table model.
    plan_row_t plan [DIRECTED] = '{
        '{FUNC_FIRST,  64'sd0, 32'd0, 1'b0, 1'b0, 1'b1, '{STATUS_NONE, 64'sd0, 32'd0, 9'd0}},
        '{FUNC_NEXT,   64'sd0, 32'd0, 1'b0, 1'b0, 1'b1, '{STATUS_NONE, 64'sd0, 32'd0, 9'd0}},
        '{FUNC_DELETE, 64'sd5, 32'd0, 1'b0, 1'b0, 1'b1, '{STATUS_NONE, 64'sd0, 32'd0, 9'd0}},
        '{FUNC_FIND,   KEY_MIN, 32'd0, 1'b0, 1'b0, 1'b1, '{STATUS_NONE, 64'sd0, 32'd0, 9'd0}},
        '{FUNC_SEEK,   KEY_MIN, 32'd0, 1'b0, 1'b0, 1'b1, '{STATUS_NONE, 64'sd0, 32'd0, 9'd0}},
        '{FUNC_START,  64'sd0, 32'd0, 1'b0, 1'b0, 1'b1, '{STATUS_OK, 64'sd0, 32'd0, 9'd0}},
        '{FUNC_UNUSED, KEY_MAX, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
          '{STATUS_NONE, 64'sd0, 32'd0, 9'd0}},
        '{FUNC_INSERT, KEY_MAX, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1,
          '{STATUS_OK, KEY_MAX, 32'hFFFF_FFFF, 9'd1}},
        '{FUNC_INSERT, KEY_MIN, 32'd0, 1'b1, 1'b0, 1'b1, '{STATUS_OK, KEY_MIN, 32'd0, 9'd2}},
        '{FUNC_INSERT, 64'sd0, 32'd5, 1'b1, 1'b0, 1'b1, '{STATUS_OK, 64'sd0, 32'd5, 9'd3}},
        '{FUNC_INSERT, 64'sd0, 32'd6, 1'b1, 1'b0, 1'b1, '{STATUS_DUP, 64'sd0, 32'd6, 9'd3}},
        '{FUNC_INSERT, 64'sd0, 32'd7, 1'b0, 1'b0, 1'b1, '{STATUS_OK, 64'sd0, 32'd7, 9'd4}},
        '{FUNC_FIRST,  64'sd0, 32'd0, 1'b0, 1'b0, 1'b1, '{STATUS_OK, KEY_MIN, 32'd0, 9'd4}},
        '{FUNC_FIND,   -64'sd1, 32'd0, 1'b0, 1'b0, 1'b0, '0},
        '{FUNC_START,  64'sd0, 32'd0, 1'b0, 1'b1, 1'b1, '{STATUS_OK, 64'sd0, 32'd0, 9'd4}},
        '{FUNC_NEXT,   64'sd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
        '{FUNC_SEEK,   64'sd1, 32'd0, 1'b0, 1'b0, 1'b0, '0},
        '{FUNC_DELETE, KEY_MAX, 32'd0, 1'b0, 1'b0, 1'b0, '0},
        '{FUNC_NEXT,   64'sd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
        '{FUNC_START,  64'sd0, 32'd0, 1'b0, 1'b0, 1'b1, '{STATUS_OK, 64'sd0, 32'd0, 9'd3}},
        '{FUNC_NEXT,   64'sd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
        '{FUNC_INSERT, -64'sd5, 32'hA5A5_A5A5, 1'b0, 1'b0, 1'b0, '0},
        '{FUNC_DELETE, 64'sd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
        '{FUNC_NEXT,   64'sd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
        '{FUNC_SEEK,   KEY_MAX, 32'd0, 1'b0, 1'b0, 1'b0, '0}
    };

    // Offers one request word, holding it steady until the block takes it,
    // then books the result word owed for it. Called at a rising edge.
    task automatic send_request(input logic [2:0] fn, input logic signed [63:0] k,
                                input logic [31:0] h, input logic uq, input logic rv,
                                input logic known, input result_t want);
        result_t guess;
        while (!calm() && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= fn;
        key         <= k;
        handle_in   <= h;
        unique_only <= uq;
        reverse_dir <= rv;
        // in_stall is read just after the edge, so it is the value the block
        // saw at that edge.
        do
            @(posedge clk);
        while (in_stall);
        guess = apply_to_table(fn, k, h, uq, rv);
        pending_results.push_back(known ? want : guess);
    endtask

    // Keys are drawn so that hits, near misses and duplicates are common:
    // mostly keys already in the table or a small cluster around zero, with
    // the extremes and full-width random keys mixed in.
    function automatic logic signed [63:0] pick_key();
        logic signed [63:0] k;
        int sel;
        sel = $urandom_range(99);
        if (sel < 45 && tbl_count > 0)
            k = tbl_key[$urandom_range(tbl_count - 1)];
        else if (sel < 75)
        begin
            k = $urandom_range(16);
            k = k - 64'sd8;
        end
        else if (sel < 85)
        begin
            case ($urandom_range(3))
                0: k = KEY_MIN;
                1: k = KEY_MAX;
                2: k = KEY_MIN + 64'sd1;
                default: k = KEY_MAX - 64'sd1;
            endcase
        end
        else
            k = {$urandom(), $urandom()};
        return k;
    endfunction

    // The random part runs in four phases: mixed traffic, a growth phase that
    // drives the table to full and keeps knocking on it, mixed traffic on a
    // big table, then a shrink phase that deletes mostly present keys.
    task automatic random_request(input int phase);
        int w_ins;
        int w_del;
        int roll;
        logic [2:0] fn;
        logic signed [63:0] k;
        logic uq;
        case (phase)
            1:
            begin
                w_ins = 85;
                w_del = 3;
            end
            3:
            begin
                w_ins = 8;
                w_del = 80;
            end
            default:
            begin
                w_ins = 30;
                w_del = 20;
            end
        endcase
        roll = $urandom_range(99);
        if (roll < w_ins)
            fn = FUNC_INSERT;
        else if (roll < w_ins + w_del)
            fn = FUNC_DELETE;
        else
        begin
            // Iterator steps get the largest share so that walks run long.
            case ($urandom_range(15))
                0: fn = FUNC_FIRST;
                1, 2: fn = FUNC_FIND;
                3, 4: fn = FUNC_START;
                5, 6: fn = FUNC_SEEK;
                15: fn = FUNC_UNUSED;
                default: fn = FUNC_NEXT;
            endcase
        end
        if (fn == FUNC_DELETE && tbl_count > 0 && $urandom_range(4) != 0)
            k = tbl_key[$urandom_range(tbl_count - 1)];
        else
            k = pick_key();
        // Fewer refusals while growing, so that the table really fills.
        uq = (phase == 1) ? ($urandom_range(3) == 0) : 1'($urandom_range(1));
        send_request(fn, k, $urandom(), uq, 1'($urandom_range(1)), 1'b0, '0);
    endtask

    initial
    begin : stimulus
        int n;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = FUNC_INSERT;
        key         = '0;
        handle_in   = '0;
        unique_only = 1'b0;
        reverse_dir = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIRECTED; n++)
        begin
            send_request(plan[n].fn, plan[n].key, plan[n].handle, plan[n].uniq,
                         plan[n].rev, plan[n].known, plan[n].want);
        end
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            random_request(n / PHASE_LEN);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        // Anything arriving in this window has no word owed and is flagged.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("sorted_key_table test passed");
        else
            $display("sorted_key_table test failed");
        $finish;
    end

    // Result side: random stall, then each word taken is compared field by
    // field with the oldest word owed.
    always @(posedge clk)
    begin : check_results
        result_t want;
        out_stall <= !calm() && ($urandom_range(99) < 30);
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors <= errors + 1;
                if (errors < 10)
                    $display("cycle %0d: result word with none owed: status %0d key %0d",
                             cycle_no, status, key_out);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || key_out !== want.key
                    || handle_out !== want.handle || entry_count !== want.count)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                    begin
                        $display("cycle %0d: mismatch", cycle_no);
                        $display("  expected status %0d key %0d handle %h count %0d",
                                 want.status, want.key, want.handle, want.count);
                        $display("  actual   status %0d key %0d handle %h count %0d",
                                 status, key_out, handle_out, entry_count);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        wait (cycle_no >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_no);
        $display("sorted_key_table test failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/skt_pkg.sv
rtl/skt_read_tree.sv
rtl/skt_cell.sv
rtl/sorted_key_table.sv
verif/sorted_key_table_tb.sv
